// File: sv/pts_pkg.sv
// Shared types, constants and helpers for the priority task scheduler.
package pts_pkg;

    // Scheduler sizing
    localparam int NUM_TASKS  = 8;
    localparam int DELAY_BITS = 32;
    localparam int TASK_W     = $clog2(NUM_TASKS);

    // Transaction field widths
    localparam int CMD_W      = 4;
    localparam int TASK_REQ_W = 8;
    localparam int TICKS_W    = 32;
    localparam int TIME_W     = 32;
    localparam int NEST_W     = 8;
    localparam int OUT_TASK_W = 3;
    localparam int OUT_MASK_W = 8;

    // Interrupt nesting saturates here
    localparam logic [NEST_W-1:0] SAT_DEPTH = 8'd255;

    typedef logic [TASK_W-1:0]     t_task;
    typedef logic [NUM_TASKS-1:0]  t_mask;
    typedef logic [DELAY_BITS-1:0] t_delay;
    typedef logic [OUT_TASK_W-1:0] t_out_task;
    typedef logic [OUT_MASK_W-1:0] t_out_mask;

    // Command codes carried in the cmd field
    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE    = 4'd0,
        CMD_RESUME    = 4'd1,
        CMD_SUSPEND   = 4'd2,
        CMD_DELAY_CUR = 4'd3,
        CMD_CANCEL    = 4'd4,
        CMD_TICK      = 4'd5,
        CMD_INT_ENTER = 4'd6,
        CMD_INT_EXIT  = 4'd7,
        CMD_START     = 4'd8,
        CMD_SWITCH    = 4'd9
    } t_cmd;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK,
        ST_RESCHED,
        ST_WAIT_OUT
    } t_state;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_ERROR,
        OP_CREATE,
        OP_SET_READY,
        OP_CLR_READY,
        OP_DELAY_CUR,
        OP_CANCEL,
        OP_TIME_INC,
        OP_TICK_STEP,
        OP_NEST_INC,
        OP_NEST_DEC,
        OP_START,
        OP_SET_TIME,
        OP_SWITCH_DONE,
        OP_RESCHED,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             bad;
        logic             started;
        logic             delay_zero;
        logic             is_current;
        logic             set_time;
        logic             tick_last;
    } t_dp_status;

    // Highest-numbered set bit; zero when none is set
    function automatic t_task find_highest(input t_mask m);
        t_task h;
        h = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            if (m[i]) begin
                h = t_task'(i);
            end
        end
        return h;
    endfunction

endpackage

// File: sv/pts_in_if.sv
// Command channel: valid/ready handshake with the command payload.
interface pts_in_if;
    logic                           valid;
    logic                           ready;
    logic [pts_pkg::CMD_W-1:0]      cmd;
    logic [pts_pkg::TASK_REQ_W-1:0] task_req;
    logic [pts_pkg::TICKS_W-1:0]    ticks;
    logic                           set_time;

    modport source (output valid, output cmd, output task_req, output ticks,
                    output set_time, input ready);
    modport sink   (input valid, input cmd, input task_req, input ticks,
                    input set_time, output ready);
endinterface

// File: sv/pts_out_if.sv
// Result channel: valid/ready handshake with the scheduler snapshot.
interface pts_out_if;
    logic                           valid;
    logic                           ready;
    logic                           status;
    logic                           switch_request;
    logic [pts_pkg::OUT_TASK_W-1:0] high_ready;
    logic [pts_pkg::OUT_TASK_W-1:0] current;
    logic [pts_pkg::OUT_MASK_W-1:0] ready_mask;
    logic [pts_pkg::TIME_W-1:0]     time_now;
    logic                           is_running;
    logic [pts_pkg::NEST_W-1:0]     int_depth;

    modport source (output valid, output status, output switch_request,
                    output high_ready, output current, output ready_mask,
                    output time_now, output is_running, output int_depth,
                    input ready);
    modport sink   (input valid, input status, input switch_request,
                    input high_ready, input current, input ready_mask,
                    input time_now, input is_running, input int_depth,
                    output ready);
endinterface

// File: sv/pts_dp.sv
// Scheduler datapath: task state, delay counters, time, nesting and result register.
module pts_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pts_pkg::t_dp_cmd               i_cmd,
    input  logic [pts_pkg::CMD_W-1:0]      i_cmd_code,
    input  logic [pts_pkg::TASK_REQ_W-1:0] i_task_req,
    input  logic [pts_pkg::TICKS_W-1:0]    i_ticks,
    input  logic                           i_set_time,
    output pts_pkg::t_dp_status            o_status,
    output logic                           o_res_status,
    output logic                           o_switch_request,
    output pts_pkg::t_out_task             o_high_ready,
    output pts_pkg::t_out_task             o_current,
    output pts_pkg::t_out_mask             o_ready_mask,
    output logic [pts_pkg::TIME_W-1:0]     o_time_now,
    output logic                           o_is_running,
    output logic [pts_pkg::NEST_W-1:0]     o_int_depth
);

    // Captured transaction
    logic [pts_pkg::CMD_W-1:0]      r_cmd;
    logic [pts_pkg::TASK_REQ_W-1:0] r_task;
    logic [pts_pkg::TICKS_W-1:0]    r_ticks;
    logic                           r_set_time;

    // Scheduler state
    pts_pkg::t_mask                 r_ready;
    pts_pkg::t_delay                r_delay [pts_pkg::NUM_TASKS];
    pts_pkg::t_task                 r_current;
    pts_pkg::t_task                 r_chosen;
    logic                           r_started;
    logic [pts_pkg::NEST_W-1:0]     r_nesting;
    logic [pts_pkg::TIME_W-1:0]     r_time;
    pts_pkg::t_task                 r_idx;
    logic                           r_err;
    logic                           r_sw;

    // Result register
    logic                           r_o_status;
    logic                           r_o_sw;
    pts_pkg::t_out_task             r_o_high;
    pts_pkg::t_out_task             r_o_current;
    pts_pkg::t_out_mask             r_o_mask;
    logic [pts_pkg::TIME_W-1:0]     r_o_time;
    logic                           r_o_running;
    logic [pts_pkg::NEST_W-1:0]     r_o_depth;

    pts_pkg::t_task                 task_idx;
    pts_pkg::t_task                 rd_addr;
    pts_pkg::t_delay                rd_delay;
    pts_pkg::t_task                 hi_idx;
    logic                           any_ready;

    // Single read port on the delay counters: tick sweep index or named task
    assign task_idx  = r_task[pts_pkg::TASK_W-1:0];
    assign rd_addr   = (r_cmd == pts_pkg::CMD_TICK) ? r_idx : task_idx;
    assign rd_delay  = r_delay[rd_addr];
    assign hi_idx    = pts_pkg::find_highest(r_ready);
    assign any_ready = |r_ready;

    // Status toward the controller
    always_comb begin
        o_status.cmd        = r_cmd;
        o_status.bad        = (int'(r_task) >= pts_pkg::NUM_TASKS);
        o_status.started    = r_started;
        o_status.delay_zero = (rd_delay == '0);
        o_status.is_current = (task_idx == r_current);
        o_status.set_time   = r_set_time;
        o_status.tick_last  = (r_idx == '0);
    end

    // Capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pts_pkg::OP_CAPTURE) begin
            r_task     <= i_task_req;
            r_ticks    <= i_ticks;
            r_set_time <= i_set_time;
        end
    end

    // Command code is reset so the read-port select is defined after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= '0;
        end else if (i_cmd.op == pts_pkg::OP_CAPTURE) begin
            r_cmd <= i_cmd_code;
        end
    end

    // Delay counters: one write per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pts_pkg::NUM_TASKS; i++) begin
                r_delay[i] <= '0;
            end
        end else begin
            case (i_cmd.op)
                pts_pkg::OP_CREATE,
                pts_pkg::OP_CANCEL: begin
                    r_delay[task_idx] <= '0;
                end
                pts_pkg::OP_DELAY_CUR: begin
                    r_delay[r_current] <= r_ticks[pts_pkg::DELAY_BITS-1:0];
                end
                pts_pkg::OP_TICK_STEP: begin
                    if (rd_delay != '0) begin
                        r_delay[r_idx] <= rd_delay - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Ready bits, task selection, time, nesting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready   <= '0;
            r_current <= '0;
            r_chosen  <= '0;
            r_started <= 1'b0;
            r_nesting <= '0;
            r_time    <= '0;
            r_idx     <= '0;
            r_err     <= 1'b0;
            r_sw      <= 1'b0;
        end else begin
            case (i_cmd.op)
                pts_pkg::OP_CAPTURE: begin
                    r_err <= 1'b0;
                    r_sw  <= 1'b0;
                end
                pts_pkg::OP_ERROR: begin
                    r_err <= 1'b1;
                end
                pts_pkg::OP_CREATE,
                pts_pkg::OP_SET_READY,
                pts_pkg::OP_CANCEL: begin
                    r_ready[task_idx] <= 1'b1;
                end
                pts_pkg::OP_CLR_READY: begin
                    r_ready[task_idx] <= 1'b0;
                end
                pts_pkg::OP_DELAY_CUR: begin
                    r_ready[r_current] <= 1'b0;
                end
                pts_pkg::OP_TIME_INC: begin
                    r_time <= r_time + 1'b1;
                    r_idx  <= pts_pkg::t_task'(pts_pkg::NUM_TASKS - 1);
                end
                pts_pkg::OP_TICK_STEP: begin
                    // Counter expiring this step makes its task ready
                    if (rd_delay == pts_pkg::t_delay'(1)) begin
                        r_ready[r_idx] <= 1'b1;
                    end
                    r_idx <= r_idx - 1'b1;
                end
                pts_pkg::OP_NEST_INC: begin
                    if (r_nesting != pts_pkg::SAT_DEPTH) begin
                        r_nesting <= r_nesting + 1'b1;
                    end
                end
                pts_pkg::OP_NEST_DEC: begin
                    if (r_nesting != '0) begin
                        r_nesting <= r_nesting - 1'b1;
                    end
                end
                pts_pkg::OP_START: begin
                    if (!r_started && any_ready) begin
                        r_chosen  <= hi_idx;
                        r_current <= hi_idx;
                        r_started <= 1'b1;
                    end
                end
                pts_pkg::OP_SET_TIME: begin
                    r_time <= r_ticks;
                end
                pts_pkg::OP_SWITCH_DONE: begin
                    r_current <= r_chosen;
                end
                pts_pkg::OP_RESCHED: begin
                    // No reschedule while nested; empty ready set keeps old choice
                    if (r_nesting == '0) begin
                        if (any_ready) begin
                            r_chosen <= hi_idx;
                            r_sw     <= (hi_idx != r_current);
                        end else begin
                            r_sw     <= (r_chosen != r_current);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result register, loaded once the transaction is finished
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pts_pkg::OP_EMIT) begin
            r_o_status  <= r_err;
            r_o_sw      <= r_sw;
            r_o_high    <= pts_pkg::t_out_task'(r_chosen);
            r_o_current <= pts_pkg::t_out_task'(r_current);
            r_o_mask    <= pts_pkg::t_out_mask'(r_ready);
            r_o_time    <= r_time;
            r_o_running <= r_started;
            r_o_depth   <= r_nesting;
        end
    end

    assign o_res_status     = r_o_status;
    assign o_switch_request = r_o_sw;
    assign o_high_ready     = r_o_high;
    assign o_current        = r_o_current;
    assign o_ready_mask     = r_o_mask;
    assign o_time_now       = r_o_time;
    assign o_is_running     = r_o_running;
    assign o_int_depth      = r_o_depth;

endmodule

// File: sv/pts_ctrl.sv
// Scheduler controller: sequences capture, execute, tick sweep, reschedule and output.
module pts_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  pts_pkg::t_dp_status i_status,
    output pts_pkg::t_dp_cmd    o_dp_cmd
);

    pts_pkg::t_state r_state;
    pts_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pts_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath operation
    always_comb begin
        n_state     = r_state;
        o_dp_cmd.op = pts_pkg::OP_NONE;
        o_in_ready  = 1'b0;
        case (r_state)
            pts_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_dp_cmd.op = pts_pkg::OP_CAPTURE;
                    n_state     = pts_pkg::ST_EXEC;
                end
            end
            pts_pkg::ST_EXEC: begin
                n_state = pts_pkg::ST_WAIT_OUT;
                case (i_status.cmd)
                    pts_pkg::CMD_CREATE: begin
                        if (i_status.bad) begin
                            o_dp_cmd.op = pts_pkg::OP_ERROR;
                        end else begin
                            o_dp_cmd.op = pts_pkg::OP_CREATE;
                            if (i_status.started) begin
                                n_state = pts_pkg::ST_RESCHED;
                            end
                        end
                    end
                    pts_pkg::CMD_RESUME: begin
                        if (i_status.bad) begin
                            o_dp_cmd.op = pts_pkg::OP_ERROR;
                        end else if (i_status.delay_zero) begin
                            o_dp_cmd.op = pts_pkg::OP_SET_READY;
                            n_state     = pts_pkg::ST_RESCHED;
                        end
                    end
                    pts_pkg::CMD_SUSPEND: begin
                        if (i_status.bad) begin
                            o_dp_cmd.op = pts_pkg::OP_ERROR;
                        end else begin
                            o_dp_cmd.op = pts_pkg::OP_CLR_READY;
                            if (i_status.is_current) begin
                                n_state = pts_pkg::ST_RESCHED;
                            end
                        end
                    end
                    pts_pkg::CMD_DELAY_CUR: begin
                        o_dp_cmd.op = pts_pkg::OP_DELAY_CUR;
                        n_state     = pts_pkg::ST_RESCHED;
                    end
                    pts_pkg::CMD_CANCEL: begin
                        if (i_status.bad) begin
                            o_dp_cmd.op = pts_pkg::OP_ERROR;
                        end else if (!i_status.delay_zero) begin
                            o_dp_cmd.op = pts_pkg::OP_CANCEL;
                            n_state     = pts_pkg::ST_RESCHED;
                        end
                    end
                    pts_pkg::CMD_TICK: begin
                        if (i_status.started) begin
                            o_dp_cmd.op = pts_pkg::OP_TIME_INC;
                            n_state     = pts_pkg::ST_TICK;
                        end
                    end
                    pts_pkg::CMD_INT_ENTER: begin
                        if (i_status.started) begin
                            o_dp_cmd.op = pts_pkg::OP_NEST_INC;
                        end
                    end
                    pts_pkg::CMD_INT_EXIT: begin
                        if (i_status.started) begin
                            o_dp_cmd.op = pts_pkg::OP_NEST_DEC;
                            n_state     = pts_pkg::ST_RESCHED;
                        end
                    end
                    pts_pkg::CMD_START: begin
                        o_dp_cmd.op = pts_pkg::OP_START;
                    end
                    pts_pkg::CMD_SWITCH: begin
                        o_dp_cmd.op = i_status.set_time ? pts_pkg::OP_SET_TIME
                                                        : pts_pkg::OP_SWITCH_DONE;
                    end
                    default: begin
                    end
                endcase
            end
            pts_pkg::ST_TICK: begin
                // One delay counter per cycle, highest index first
                o_dp_cmd.op = pts_pkg::OP_TICK_STEP;
                if (i_status.tick_last) begin
                    n_state = pts_pkg::ST_WAIT_OUT;
                end
            end
            pts_pkg::ST_RESCHED: begin
                o_dp_cmd.op = pts_pkg::OP_RESCHED;
                n_state     = pts_pkg::ST_WAIT_OUT;
            end
            pts_pkg::ST_WAIT_OUT: begin
                if (out_free) begin
                    o_dp_cmd.op = pts_pkg::OP_EMIT;
                    n_state     = pts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pts_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register valid: set on load, cleared when taken
    always_comb begin
        if (o_dp_cmd.op == pts_pkg::OP_EMIT) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // Checks
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == pts_pkg::ST_EXEC))
        else $error("accepted transaction did not enter execute");

    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dp_cmd.op == pts_pkg::OP_EMIT) |-> out_free)
        else $error("result loaded over an untaken result");

    a_tick_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pts_pkg::ST_TICK && i_status.tick_last)
            |=> (r_state == pts_pkg::ST_WAIT_OUT))
        else $error("tick sweep did not finish after the last counter");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dp_cmd.op == pts_pkg::OP_EMIT) |=> (o_out_valid && r_state == pts_pkg::ST_IDLE))
        else $error("loaded result not presented");

endmodule

// File: sv/priority_task_scheduler_unit.sv
// Top level of the priority task scheduler.
// One command transaction in gives one result transaction out. A command passes through
// capture, execute and output load, with a reschedule step before the output load when it
// reschedules; a tick adds a sweep after execute, since the delay counters sit behind a
// single read/decrement port and are walked one task per cycle. The result is presented
// the cycle after the output load, and a result left untaken stalls the output load.
// A new command is taken only while the controller is idle, but a finished result may
// still wait in the output register while the next command is accepted. Unless interrupts
// are nested, rescheduling picks the highest-numbered ready task and flags a switch when it
// differs from the running task; status reports a task index out of range.
module priority_task_scheduler_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pts_in_if.sink     i_in,
    pts_out_if.source  o_out
);

    pts_pkg::t_dp_cmd    dp_cmd;
    pts_pkg::t_dp_status dp_status;

    pts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (dp_status),
        .o_dp_cmd    (dp_cmd)
    );

    pts_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_cmd_code       (i_in.cmd),
        .i_task_req       (i_in.task_req),
        .i_ticks          (i_in.ticks),
        .i_set_time       (i_in.set_time),
        .o_status         (dp_status),
        .o_res_status     (o_out.status),
        .o_switch_request (o_out.switch_request),
        .o_high_ready     (o_out.high_ready),
        .o_current        (o_out.current),
        .o_ready_mask     (o_out.ready_mask),
        .o_time_now       (o_out.time_now),
        .o_is_running     (o_out.is_running),
        .o_int_depth      (o_out.int_depth)
    );

endmodule
